@@ rtl/sync_length_frame_extractor_top_assert.svh @@
// Assertion macros for the sync length frame extractor.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef SYNC_LENGTH_FRAME_EXTRACTOR_TOP_ASSERT_SVH
`define SYNC_LENGTH_FRAME_EXTRACTOR_TOP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define SLFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SLFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/slfe_pkg.sv @@
// Shared types and constants for the sync length frame extractor.
// No dependencies.
package slfe_pkg;

  localparam int unsigned MaxFrameLenDefault = 2048;
  localparam int unsigned CallerBufResetVal  = 2048;
  localparam int unsigned LenW               = 12;
  localparam int unsigned HeaderLen          = 6;
  localparam int unsigned FifoDepth          = 8;

  localparam logic [7:0] SyncByte = 8'h23;

  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhSync1  = 3'd1;
  localparam logic [2:0] PhSync2  = 3'd2;
  localparam logic [2:0] PhSync3  = 3'd3;
  localparam logic [2:0] PhLenLo  = 3'd4;
  localparam logic [2:0] PhLenHi  = 3'd5;
  localparam logic [2:0] PhBody   = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } slfe_beat_t;

endpackage

@@ rtl/sync_length_frame_extractor_top.sv @@
// Top level of the sync length frame extractor: parser and output queue.
// Depends on slfe_pkg and sync_length_frame_extractor_top_assert.svh.
//
// Usage: received bytes enter on the s_axis channel, one request per byte.
// The parser hunts for four 0x23 sync bytes followed by a little-endian
// 16-bit total length that includes the six header bytes. Frames whose
// length is at least six, at most MAX_FRAME_LEN and at most the value in
// the caller buffer register are delivered on m_axis, header included,
// with tuser marking the first byte and tlast the final one. Other frames
// are dropped or consumed without output.
// Result bytes pass through the registered output queue to m_axis.
// Throughput: one byte per cycle while the queue has room. The high
// length byte releases all six header bytes at once into an eight-entry
// output queue; it is accepted only when six entries are free, other
// bytes need one free entry. With an always-ready receiver the queue
// drains during the next sync hunt, so the input is never stalled.
// Reset clears the parser to hunting, empties the queue and sets the
// caller buffer register to 2048. When the receiver stalls, the queue
// fills and s_axis_tready falls; no byte is lost.
module sync_length_frame_extractor_top #(
  parameter int unsigned MAX_FRAME_LEN = slfe_pkg::MaxFrameLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [slfe_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] frame_byte
  output logic                      m_axis_tuser,   // [0] frame_first
  output logic                      m_axis_tlast    // frame_last
);
  import slfe_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [LenW-1:0]    caller_len_q;
  logic [2:0]         phase_q, phase_d;
  logic [7:0]         len_lo_q, len_lo_d;
  logic [LenW-1:0]    frame_len_q, frame_len_d;
  logic [LenW-1:0]    seen_q, seen_d;
  logic               skip_q, skip_d;

  slfe_beat_t         fifo_q [FifoDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  slfe_beat_t         wr_beat [HeaderLen];
  logic [2:0]         wr_cnt;
  logic               in_acc, pop;
  logic [15:0]        len;
  logic [LenW-1:0]    seen_inc;
  logic               body_last;
  logic               hdr_room;
  logic               body_ok;

  assign len       = {s_axis_tdata, len_lo_q};
  assign seen_inc  = seen_q + LenW'(1);
  assign body_last = (seen_inc >= frame_len_q);
  assign hdr_room  = (count_q <= CntW'(FifoDepth - HeaderLen));
  assign body_ok   = (frame_len_q > LenW'(HeaderLen)) && (seen_q < frame_len_q);

  assign s_axis_tready = (phase_q == PhLenHi) ? hdr_room :
                         (count_q < CntW'(FifoDepth));
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_d     = phase_q;
    len_lo_d    = len_lo_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    skip_d      = skip_q;
    wr_cnt      = 3'd0;
    for (int k = 0; k < HeaderLen; k++) begin
      wr_beat[k] = '{data: SyncByte, first: 1'b0, last: 1'b0};
    end
    wr_beat[0].first = 1'b1;
    wr_beat[4].data  = len_lo_q;
    wr_beat[5].data  = s_axis_tdata;
    wr_beat[5].last  = (len == 16'(HeaderLen));
    case (phase_q)
      PhSync1, PhSync2, PhSync3: begin
        phase_d = (s_axis_tdata == SyncByte) ? phase_q + 3'd1 : PhHunt;
      end
      PhLenLo: begin
        len_lo_d = s_axis_tdata;
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        phase_d = PhHunt;
        if (!(len > 16'(MAX_FRAME_LEN) || len < 16'(HeaderLen))) begin
          frame_len_d = len[LenW-1:0];
          seen_d      = LenW'(HeaderLen);
          skip_d      = (len > {{(16-LenW){1'b0}}, caller_len_q});
          if (!skip_d) begin
            wr_cnt = 3'(HeaderLen);
          end
          if (len > 16'(HeaderLen)) begin
            phase_d = PhBody;
          end else begin
            skip_d = 1'b0;
          end
        end
      end
      PhBody: begin
        seen_d     = seen_inc;
        wr_beat[0] = '{data: s_axis_tdata, first: 1'b0, last: body_last};
        if (!skip_q) begin
          wr_cnt = 3'd1;
        end
        if (body_last) begin
          phase_d = PhHunt;
          skip_d  = 1'b0;
        end
      end
      default: begin
        phase_d = (s_axis_tdata == SyncByte) ? PhSync1 : PhHunt;
      end
    endcase
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].data;
  assign m_axis_tuser  = fifo_q[rd_ptr_q].first;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caller_len_q <= LenW'(CallerBufResetVal);
      phase_q      <= PhHunt;
      len_lo_q     <= '0;
      frame_len_q  <= '0;
      seen_q       <= '0;
      skip_q       <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        caller_len_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        len_lo_q    <= len_lo_d;
        frame_len_q <= frame_len_d;
        seen_q      <= seen_d;
        skip_q      <= skip_d;
        wr_ptr_q    <= wr_ptr_q + PtrW'(wr_cnt);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (in_acc ? CntW'(wr_cnt) : CntW'(0)) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < HeaderLen; k++) begin
        if (3'(k) < wr_cnt) begin
          fifo_q[wr_ptr_q + PtrW'(k)] <= wr_beat[k];
        end
      end
    end
  end

`include "sync_length_frame_extractor_top_assert.svh"

  `SLFE_ASSERT(a_count_bound, count_q <= CntW'(FifoDepth), "output queue overflow")
  `SLFE_ASSERT(a_hdr_room, (in_acc && phase_q == PhLenHi) |-> hdr_room, "header without room")
  `SLFE_ASSERT(a_first_is_sync, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == SyncByte), "bad first")
  `SLFE_ASSERT(a_body_len, (phase_q == PhBody) |-> body_ok, "body phase with bad length")
  `SLFE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (count_q == '0 || rst_ni), "queue not empty")

endmodule
